[hdl/ihpt_pkg.sv]
// ----------------------------------------------------------------------------
// ihpt_pkg
// shared controller/datapath command and status types
// ----------------------------------------------------------------------------
package ihpt_pkg;

    typedef struct packed {
        logic load;        // capture a new request
        logic probe;       // compare current chain node, step
        logic hit_touch;   // lru update on hit
        logic rm_step;     // eviction chain walk step
        logic fill;        // install frame and advance oldest
        logic emit;        // drive result strobe
    } t_cmd;

    typedef struct packed {
        logic chain_end;   // current pointer empty or walk bound reached
        logic match;       // current node matches
        logic victim_used; // oldest frame is in use
        logic rm_done;     // eviction unlink finished
    } t_sts;

endpackage

[hdl/ihpt_ctrl.sv]
// ----------------------------------------------------------------------------
// ihpt_ctrl
// sequencer for lookup walk, lru update, eviction walk and fill
// ----------------------------------------------------------------------------
module ihpt_ctrl
    import ihpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_HIT  = 3'd2;
    localparam logic [2:0] S_RM   = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.chain_end) begin
                    n_state = i_sts.victim_used ? S_RM : S_FILL;
                end else if (i_sts.match) begin
                    n_state = S_HIT;
                end else begin
                    o_cmd.probe = 1'b1;
                end
            end
            S_HIT: begin
                o_cmd.hit_touch = 1'b1;
                n_state         = S_OUT;
            end
            S_RM: begin
                o_cmd.rm_step = 1'b1;
                if (i_sts.rm_done) n_state = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[hdl/ihpt_dp.sv]
// ----------------------------------------------------------------------------
// ihpt_dp
// page table stores, chain walker, lru ring and result registers
// ----------------------------------------------------------------------------
module ihpt_dp
    import ihpt_pkg::*;
#(
    parameter int FRAME_BITS       = 4,
    parameter int PID_BITS         = 2,
    parameter int PAGE_OFFSET_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [1:0]          i_process_id,
    input  logic [31:0]         i_virtual_address,
    output t_sts                o_sts,
    output logic                o_valid,
    output logic [15:0]         o_physical_address,
    output logic                o_page_hit,
    output logic                o_bucket_empty,
    output logic [4:0]          o_chain_probes,
    output logic                o_evicted
);

    localparam int NF = 1 << FRAME_BITS;
    localparam int PN = 32 - PAGE_OFFSET_BITS;
    localparam int PW = FRAME_BITS + 1;
    localparam int SW = FRAME_BITS + 1;

    typedef logic [FRAME_BITS-1:0] t_fr;

    logic [PW-1:0]       r_head  [NF];
    logic [PW-1:0]       r_link  [NF];
    logic [PID_BITS-1:0] r_owner [NF];
    logic [PN-1:0]       r_page  [NF];
    logic [NF-1:0]       r_used;
    t_fr                 r_older [NF];
    t_fr                 r_newer [NF];
    t_fr                 r_oldest;

    logic [PID_BITS-1:0] r_pid;
    logic [PN-1:0]       r_vpn;
    logic [PAGE_OFFSET_BITS-1:0] r_off;
    t_fr                 r_bkt;
    logic [PW-1:0]       r_cur;
    logic [PW-1:0]       r_prev;
    logic [SW-1:0]       r_steps;
    logic [4:0]          r_probes;
    logic                r_empty;
    logic                r_hit;
    logic                r_evict;
    t_fr                 r_frame;
    t_fr                 r_rbkt;
    logic                r_rm_done;
    logic                r_valid;

    logic [PID_BITS-1:0] w_pid;
    logic [PN-1:0]       w_vpn;
    t_fr                 w_bkt;
    t_fr                 w_cf;
    logic                w_match;
    logic                w_end;
    logic [PW-1:0]       w_empty_ptr;
    logic [PW-1:0]       w_rm_link;
    t_fr                 w_vf;
    logic [PAGE_OFFSET_BITS+FRAME_BITS-1:0] w_pa;

    assign w_empty_ptr = PW'(NF);
    assign w_pid = PID_BITS'(i_process_id);
    assign w_vpn = i_virtual_address[31:PAGE_OFFSET_BITS];
    assign w_bkt = FRAME_BITS'(w_vpn) + FRAME_BITS'(w_pid);
    assign w_cf  = r_cur[FRAME_BITS-1:0];
    assign w_end = r_cur[FRAME_BITS] || (r_steps == SW'(NF));
    assign w_match = r_used[w_cf] && (r_owner[w_cf] == r_pid) && (r_page[w_cf] == r_vpn);
    assign w_vf = r_oldest;
    assign w_rm_link = r_link[w_cf];

    assign o_sts.chain_end   = w_end;
    assign o_sts.match       = w_match;
    assign o_sts.victim_used = r_used[w_vf];
    assign o_sts.rm_done     = r_rm_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NF; i++) begin
                r_head[i]  <= w_empty_ptr;
                r_link[i]  <= w_empty_ptr;
                r_older[i] <= t_fr'(i - 1);
                r_newer[i] <= t_fr'(i + 1);
            end
            r_used    <= '0;
            r_oldest  <= '0;
            r_valid   <= 1'b0;
            r_rm_done <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.load) begin
                r_pid     <= w_pid;
                r_vpn     <= w_vpn;
                r_off     <= i_virtual_address[PAGE_OFFSET_BITS-1:0];
                r_bkt     <= w_bkt;
                r_cur     <= r_head[w_bkt];
                r_empty   <= r_head[w_bkt][FRAME_BITS];
                r_steps   <= '0;
                r_probes  <= '0;
                r_hit     <= 1'b0;
                r_evict   <= 1'b0;
                r_rm_done <= 1'b0;
            end
            if (i_cmd.probe) begin
                // count this node, then step along the chain
                r_steps <= r_steps + 1'b1;
                if (r_probes != 5'd31) r_probes <= r_probes + 1'b1;
                r_cur <= r_link[w_cf];
            end
            // walk ends in a match: count the matching node
            if (!w_end && w_match && !i_cmd.probe && !i_cmd.load && !r_hit
                && !i_cmd.hit_touch && !i_cmd.emit && !i_cmd.fill && !i_cmd.rm_step) begin
                r_hit   <= 1'b1;
                r_frame <= w_cf;
                if (r_probes != 5'd31) r_probes <= r_probes + 1'b1;
            end
            if (i_cmd.hit_touch) begin
                if (r_frame == r_oldest) begin
                    r_oldest <= r_newer[r_oldest];
                end else if (r_older[r_oldest] != r_frame) begin
                    // the newest frame stays where it is
                    r_newer[r_older[r_frame]] <= r_newer[r_frame];
                    r_older[r_newer[r_frame]] <= r_older[r_frame];
                    r_newer[r_older[r_oldest]] <= r_frame;
                    r_older[r_frame] <= r_older[r_oldest];
                    r_newer[r_frame] <= r_oldest;
                    r_older[r_oldest] <= r_frame;
                end
            end
            if (i_cmd.rm_step) begin
                if (!r_evict) begin
                    // first cycle: start the unlink walk at the victim's bucket
                    r_evict <= 1'b1;
                    r_rbkt  <= FRAME_BITS'(r_page[w_vf]) + FRAME_BITS'(r_owner[w_vf]);
                    r_cur   <= r_head[FRAME_BITS'(r_page[w_vf])
                                      + FRAME_BITS'(r_owner[w_vf])];
                    r_prev  <= w_empty_ptr;
                    r_steps <= '0;
                end else if (!r_rm_done) begin
                    if (r_cur[FRAME_BITS] || r_steps == SW'(NF)) begin
                        r_rm_done <= 1'b1;
                    end else if (w_cf == w_vf) begin
                        if (r_prev[FRAME_BITS]) r_head[r_rbkt] <= w_rm_link;
                        else r_link[r_prev[FRAME_BITS-1:0]] <= w_rm_link;
                        r_link[w_cf] <= w_empty_ptr;
                        r_rm_done    <= 1'b1;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= w_rm_link;
                        r_steps <= r_steps + 1'b1;
                    end
                end
            end
            if (i_cmd.fill) begin
                r_owner[w_vf] <= r_pid;
                r_page[w_vf]  <= r_vpn;
                r_used[w_vf]  <= 1'b1;
                r_link[w_vf]  <= r_head[r_bkt];
                r_head[r_bkt] <= {1'b0, w_vf};
                r_frame       <= w_vf;
                r_oldest      <= r_newer[w_vf];
            end
        end
    end

    assign w_pa = {r_frame, r_off};
    assign o_valid            = r_valid;
    assign o_physical_address = 16'(w_pa);
    assign o_page_hit         = r_hit;
    assign o_bucket_empty     = r_empty;
    assign o_chain_probes     = r_probes;
    assign o_evicted          = r_evict;

endmodule

[hdl/inverted_hash_page_table_lru.sv]
// ----------------------------------------------------------------------------
// inverted_hash_page_table_lru
// inverted hashed page table with lru frame replacement
// ----------------------------------------------------------------------------
// One request at a time: the lookup walks the chain node by node (up to the
// frame count), a miss on a used frame adds the unlink walk of the victim's
// old chain, then the fill or lru relink and the result issue follow; busy is
// already low in the result cycle. The result is strobed on o_valid for one
// cycle; the receiver cannot stall.
module inverted_hash_page_table_lru
    import ihpt_pkg::*;
#(
    parameter int FRAME_BITS       = 4,
    parameter int PID_BITS         = 2,
    parameter int PAGE_OFFSET_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_process_id,
    input  logic [31:0] i_virtual_address,
    output logic        o_valid,
    output logic [15:0] o_physical_address,
    output logic        o_page_hit,
    output logic        o_bucket_empty,
    output logic [4:0]  o_chain_probes,
    output logic        o_evicted
);

    t_cmd w_cmd;
    t_sts w_sts;

    ihpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    ihpt_dp #(
        .FRAME_BITS       (FRAME_BITS),
        .PID_BITS         (PID_BITS),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_process_id       (i_process_id),
        .i_virtual_address  (i_virtual_address),
        .o_sts              (w_sts),
        .o_valid            (o_valid),
        .o_physical_address (o_physical_address),
        .o_page_hit         (o_page_hit),
        .o_bucket_empty     (o_bucket_empty),
        .o_chain_probes     (o_chain_probes),
        .o_evicted          (o_evicted)
    );

endmodule

[bench/ihpt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ihpt_checker
// watches request and result transfers of the page table, keeps its own
// model of chains, frames and lru ring, and compares every result
// ----------------------------------------------------------------------------
module ihpt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_process_id,
    input  logic [31:0] i_virtual_address,
    input  logic        o_valid,
    input  logic [15:0] o_physical_address,
    input  logic        o_page_hit,
    input  logic        o_bucket_empty,
    input  logic [4:0]  o_chain_probes,
    input  logic        o_evicted,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NF = 16;

    typedef struct packed {
        logic [15:0] paddr;
        logic        hit;
        logic        empty;
        logic [4:0]  probes;
        logic        evict;
    } t_xlate;

    logic [4:0]  head_q [NF];
    logic [4:0]  next_q [NF];
    logic [1:0]  owner_q [NF];
    logic [19:0] vpn_q [NF];
    logic        used_q [NF];
    logic [3:0]  older_q [NF];
    logic [3:0]  newer_q [NF];
    logic [3:0]  oldest_q;
    t_xlate      xlate_fifo [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = xlate_fifo.size();

    function automatic logic [3:0] bucket_of(logic [19:0] vpn, logic [1:0] pid);
        return 4'(vpn + 20'(pid));
    endfunction

    function automatic void unlink_frame(logic [3:0] b, logic [3:0] f);
        logic [4:0] prev;
        logic [4:0] cur;
        prev = 5'h10;
        cur  = head_q[b];
        for (int s = 0; s < NF && !cur[4]; s++) begin
            if (cur[3:0] == f) begin
                if (prev[4]) head_q[b] = next_q[cur[3:0]];
                else next_q[prev[3:0]] = next_q[cur[3:0]];
                next_q[cur[3:0]] = 5'h10;
                return;
            end
            prev = cur;
            cur  = next_q[cur[3:0]];
        end
    endfunction

    function automatic void make_newest(logic [3:0] f);
        logic [3:0] p;
        if (f == oldest_q) begin
            oldest_q = newer_q[oldest_q];
            return;
        end
        newer_q[older_q[f]] = newer_q[f];
        older_q[newer_q[f]] = older_q[f];
        p = older_q[oldest_q];
        newer_q[p] = f;
        older_q[f] = p;
        newer_q[f] = oldest_q;
        older_q[oldest_q] = f;
    endfunction

    function automatic t_xlate translate(logic [1:0] pid, logic [31:0] va);
        t_xlate     r;
        logic [19:0] vpn;
        logic [3:0]  b;
        logic [3:0]  f;
        logic [4:0]  cur;
        vpn = va[31:12];
        b   = bucket_of(vpn, pid);
        cur = head_q[b];
        r   = '0;
        f   = '0;
        r.empty = cur[4];
        for (int s = 0; s < NF && !cur[4]; s++) begin
            r.probes++;
            if (used_q[cur[3:0]] && owner_q[cur[3:0]] == pid && vpn_q[cur[3:0]] == vpn) begin
                r.hit = 1'b1;
                f = cur[3:0];
                break;
            end
            cur = next_q[cur[3:0]];
        end
        if (r.hit) begin
            make_newest(f);
        end else begin
            f = oldest_q;
            if (used_q[f]) begin
                r.evict = 1'b1;
                unlink_frame(bucket_of(vpn_q[f], owner_q[f]), f);
            end
            owner_q[f] = pid;
            vpn_q[f]   = vpn;
            used_q[f]  = 1'b1;
            next_q[f]  = head_q[b];
            head_q[b]  = {1'b0, f};
            oldest_q   = newer_q[f];
        end
        r.paddr = {f, va[11:0]};
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_xlate got;
        t_xlate want;
        if (!i_rst_n) begin
            for (int i = 0; i < NF; i++) begin
                head_q[i]  = 5'h10;
                next_q[i]  = 5'h10;
                owner_q[i] = '0;
                vpn_q[i]   = '0;
                used_q[i]  = 1'b0;
                older_q[i] = 4'(i - 1);
                newer_q[i] = 4'(i + 1);
            end
            oldest_q = '0;
            xlate_fifo.delete();
            fails = 0;
        end else begin
            if (o_valid) begin
                got = '{o_physical_address, o_page_hit, o_bucket_empty,
                        o_chain_probes, o_evicted};
                if (xlate_fifo.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    want = xlate_fifo.pop_front();
                    if (got.paddr !== want.paddr) begin
                        $error("physical_address exp %h got %h", want.paddr, got.paddr);
                        fails++;
                    end
                    if (got.hit !== want.hit) begin
                        $error("page_hit exp %b got %b", want.hit, got.hit);
                        fails++;
                    end
                    if (got.empty !== want.empty) begin
                        $error("bucket_empty exp %b got %b", want.empty, got.empty);
                        fails++;
                    end
                    if (got.probes !== want.probes) begin
                        $error("chain_probes exp %0d got %0d", want.probes, got.probes);
                        fails++;
                    end
                    if (got.evict !== want.evict) begin
                        $error("evicted exp %b got %b", want.evict, got.evict);
                        fails++;
                    end
                end
            end
            // request transfer after result check, results never overtake
            if (start && !busy)
                xlate_fifo.push_back(translate(i_process_id, i_virtual_address));
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// page table testbench: directed walks over chains and eviction, then random
// lookups from a small working set with gaps; a checker predicts the results
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG = 5000;
    localparam int NRAND    = 1600;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_process_id;
    logic [31:0] i_virtual_address;
    logic        o_valid;
    logic [15:0] o_physical_address;
    logic        o_page_hit;
    logic        o_bucket_empty;
    logic [4:0]  o_chain_probes;
    logic        o_evicted;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic [19:0] hot_pages [8];

    inverted_hash_page_table_lru dut (.*);

    ihpt_checker chk (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // start stays high after a transfer; busy masks it until the next request
    task automatic send(logic [1:0] pid, logic [31:0] va, bit gaps);
        if (gaps) begin
            while ($urandom_range(99) < 10) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start             <= 1'b1;
        i_process_id      <= pid;
        i_virtual_address <= va;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        logic [19:0] vpn;
        logic [1:0]  pid;
        start             = 1'b0;
        i_process_id      = '0;
        i_virtual_address = '0;
        i_rst_n           = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, empty bucket, hit, and pid alias into the same bucket
        send(2'd0, 32'h0000_0000, 0);
        send(2'd3, 32'hFFFF_FFFF, 0);
        send(2'd0, 32'h0000_0ABC, 0);
        send(2'd1, 32'hFFFF_F123, 0);
        send(2'd3, 32'h5555_5AAA, 0);
        send(2'd2, 32'hAAAA_A555, 0);
        // chains in four buckets: page + pid mod 16 is fixed for each run of four
        for (int i = 0; i < 17; i++)
            send(2'(i), {20'(16 * i - i), 12'(i)}, 0);
        send(2'd0, 32'h0000_0000, 0);
        drain();

        for (int i = 0; i < 8; i++) hot_pages[i] = 20'($urandom);
        for (int n = 0; n < NRAND; n++) begin
            if ($urandom_range(99) < 70) begin
                // working set larger than frame count keeps hits and evictions
                vpn = hot_pages[$urandom_range(7)] + 20'(16 * $urandom_range(3));
                pid = 2'($urandom_range(3));
            end else begin
                vpn = 20'($urandom);
                pid = 2'($urandom);
            end
            send(pid, {vpn, 12'($urandom)}, !(n >= 600 && n < 800));
            if (n == 1000) drain();
        end
        drain();

        if (fail_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
hdl/ihpt_pkg.sv
hdl/ihpt_ctrl.sv
hdl/ihpt_dp.sv
hdl/inverted_hash_page_table_lru.sv
bench/ihpt_checker.sv
bench/tb.sv
